FILE: hdl/ssdr_pkg.sv
// Shared constants, types and register indexes for the duty regulator.
// No dependencies; imported by ssdr_div and the top level.
`timescale 1ns / 1ps

package ssdr_pkg;

	// serial divider operand width: period*1000 needs 26 bits
	localparam int DIV_W = 26;
	localparam int CNT_W = 5;
	// duty correction width: increment*1000 fits in 22 bits
	localparam int Q_W = 22;
	// signed working width of the new duty
	localparam int ND_W = 24;
	// signed working width of the new period
	localparam int NP_W = 18;

	localparam logic [9:0] SCALE = 10'd1000;
	localparam logic [4:0] DUTY_STEP = 5'd10;

	// configuration register indexes
	localparam logic [2:0] REG_TARGET_V = 3'd0;
	localparam logic [2:0] REG_DUTY_FLOOR = 3'd1;
	localparam logic [2:0] REG_DUTY_CEIL = 3'd2;
	localparam logic [2:0] REG_PER_FLOOR = 3'd3;
	localparam logic [2:0] REG_PER_CEIL = 3'd4;
	localparam logic [2:0] REG_PER_INC = 3'd5;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/spread_spectrum_duty_regulator_unit.sv
// Duty regulator with triangle sweep of the switching period.
// A request goes straight to the finish state when not running or the duty is zero; else the first
// division runs in ssdr_div, then the second unless the first quotient is zero.
// A new request is stalled until the unit is back in idle; both divisions share the bit-serial divider.
// A waiting result does not block the next request from being taken.
// Reset (arst_n, asynchronous): state and configuration registers to their defaults, duty 1000, period 40000, idle.
`timescale 1ns / 1ps

module spread_spectrum_duty_regulator_unit
	import ssdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] measured_input_voltage,
	input  logic        start_request,
	input  logic        stop_request,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] duty_count,
	output logic [15:0] period_count,
	output logic        is_running,
	output logic        hit_ceiling,
	output logic        hit_floor
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV1 = 2'd1;
	localparam logic [1:0] ST_DIV2 = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]  state_q;
	logic [15:0] target_v_q, duty_floor_q, duty_ceil_q, per_floor_q, per_ceil_q;
	logic [11:0] per_inc_q;
	logic [15:0] duty_q, period_q, meas_q;
	logic        rising_q, running_q, ceil_flag_q, floor_flag_q;
	logic [Q_W-1:0] q_q;
	logic        out_valid_q;
	logic [15:0] out_duty_q, out_period_q;
	logic        out_run_q, out_ceil_q, out_floor_q;

	logic             accept, run_new, out_free, fin_go;
	logic [15:0]      duty_eff;
	logic             div_start;
	logic [DIV_W-1:0] div_num, div_den, div_quot;
	div_stat_t        div_stat;

	logic signed [NP_W-1:0] np;
	logic                   rising_new;
	logic [15:0]            period_new;
	logic signed [ND_W-1:0] qs, nd;
	logic [15:0]            duty_new;
	logic                   ceil_new, floor_new;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign duty_eff = (!stop_request && start_request) ? duty_floor_q : duty_q;
	assign run_new  = stop_request ? 1'b0 : (start_request ? 1'b1 : running_q);
	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	always_comb begin
		if (state_q == ST_IDLE) begin
			div_num = DIV_W'(period_q) * DIV_W'(SCALE);
			div_den = DIV_W'(duty_eff);
		end else begin
			div_num = DIV_W'(per_inc_q) * DIV_W'(SCALE);
			div_den = div_quot;
		end
	end

	assign div_start = (accept && run_new && duty_eff != '0)
		|| (state_q == ST_DIV1 && div_stat.done && div_quot != '0);

	ssdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// sweep step; flip decided on the unclamped period
	always_comb begin
		if (!rising_q) begin
			np         = $signed({2'b00, period_q}) - $signed({6'd0, per_inc_q});
			rising_new = (np <= $signed({2'b00, per_floor_q}));
			qs         = -$signed({2'b00, q_q});
		end else begin
			np         = $signed({2'b00, period_q}) + $signed({6'd0, per_inc_q});
			rising_new = !(np >= $signed({2'b00, per_ceil_q}));
			qs         = $signed({2'b00, q_q});
		end
		if (np < 0)
			period_new = '0;
		else if (np > $signed(NP_W'(16'hFFFF)))
			period_new = 16'hFFFF;
		else
			period_new = np[15:0];

		nd = $signed({8'd0, duty_q}) + qs;
		if (target_v_q > meas_q)
			nd = nd - $signed(ND_W'(DUTY_STEP));
		else
			nd = nd + $signed(ND_W'(DUTY_STEP));

		// ceiling test first, so with inverted bounds the ceiling wins where both tests hold
		ceil_new  = 1'b0;
		floor_new = 1'b0;
		if (nd >= $signed({8'd0, duty_ceil_q})) begin
			duty_new = duty_ceil_q;
			ceil_new = 1'b1;
		end else if (nd <= $signed({8'd0, duty_floor_q})) begin
			duty_new  = duty_floor_q;
			floor_new = 1'b1;
		end else begin
			duty_new = nd[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_v_q   <= 16'd0;
			duty_floor_q <= 16'd1000;
			duty_ceil_q  <= 16'd36000;
			per_floor_q  <= 16'd36000;
			per_ceil_q   <= 16'd40000;
			per_inc_q    <= 12'd100;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TARGET_V:   target_v_q   <= cfg_data;
				REG_DUTY_FLOOR: duty_floor_q <= cfg_data;
				REG_DUTY_CEIL:  duty_ceil_q  <= cfg_data;
				REG_PER_FLOOR:  per_floor_q  <= cfg_data;
				REG_PER_CEIL:   per_ceil_q   <= cfg_data;
				REG_PER_INC:    per_inc_q    <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			duty_q       <= 16'd1000;
			period_q     <= 16'd40000;
			rising_q     <= 1'b0;
			running_q    <= 1'b0;
			ceil_flag_q  <= 1'b0;
			floor_flag_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						running_q <= run_new;
						duty_q    <= duty_eff;
						state_q   <= div_start ? ST_DIV1 : ST_FIN;
					end
				end
				ST_DIV1: begin
					if (div_stat.done)
						state_q <= (div_quot != '0) ? ST_DIV2 : ST_FIN;
				end
				ST_DIV2: begin
					if (div_stat.done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (running_q) begin
							duty_q       <= duty_new;
							period_q     <= period_new;
							rising_q     <= rising_new;
							ceil_flag_q  <= ceil_new;
							floor_flag_q <= floor_new;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload, correction and output result
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= measured_input_voltage;
			q_q    <= '0;
		end else if (state_q == ST_DIV2 && div_stat.done) begin
			q_q <= div_quot[Q_W-1:0];
		end
		if (fin_go) begin
			out_duty_q   <= running_q ? duty_new : duty_q;
			out_period_q <= running_q ? period_new : period_q;
			out_run_q    <= running_q;
			out_ceil_q   <= running_q ? ceil_new : ceil_flag_q;
			out_floor_q  <= running_q ? floor_new : floor_flag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign duty_count   = out_duty_q;
	assign period_count = out_period_q;
	assign is_running   = out_run_q;
	assign hit_ceiling  = out_ceil_q;
	assign hit_floor    = out_floor_q;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ceil_flag_q && floor_flag_q))
		else $error("both duty limit flags set");
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIV1 || state_q == ST_FIN))
		else $error("request taken without entering divide or finish");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider running outside a divide state");

endmodule

FILE: hdl/ssdr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ssdr_pkg.
`timescale 1ns / 1ps

module ssdr_div
	import ssdr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output div_stat_t        stat,
	output logic [DIV_W-1:0] quot
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W+1:0] diff;
	logic             qbit;

	// numerator bits shift out of the top of quo_q, quotient bits in at the bottom
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign qbit  = !diff[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != CNT_W'(DIV_W - 1)) |-> (rem_q < den_q || den_q == '0))
		else $error("partial remainder not below divisor");

endmodule

FILE: bench/tb_spread_spectrum_duty_regulator_unit.sv
// Self-checking bench for the spread-spectrum duty regulator: directed table, then random phases.
// Holds its own model of duty, period sweep and limit flags; needs ssdr_pkg and the unit.
`timescale 1ns / 1ps

module tb_spread_spectrum_duty_regulator_unit;
	import ssdr_pkg::*;

	localparam int ITEMS_PER_PHASE = 93;
	localparam int NUM_PHASES = 10;
	localparam int PRESSURE_PHASE = 3;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [15:0] duty;
		logic [15:0] period;
		logic        running;
		logic        clamp_hi;
		logic        clamp_lo;
	} pwm_result_t;

	typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [15:0] data;
		logic [15:0] meas;
		logic        start;
		logic        stop;
		logic        typed;
		pwm_result_t want;
	} stim_row_t;

	localparam pwm_result_t AFTER_RESET = '{16'd1000, 16'd40000, 1'b0, 1'b0, 1'b0};
	// default registers: q = 100000 / 40000 = 2 negated on the down step, then +10
	localparam pwm_result_t FIRST_STEP = '{16'd1008, 16'd39900, 1'b1, 1'b0, 1'b0};

	function automatic stim_row_t req_row(logic [15:0] m, logic s, logic p);
		return '{ROW_REQ, 3'd0, 16'd0, m, s, p, 1'b0, '0};
	endfunction

	function automatic stim_row_t typed_row(logic [15:0] m, logic s, logic p, pwm_result_t w);
		return '{ROW_REQ, 3'd0, 16'd0, m, s, p, 1'b1, w};
	endfunction

	function automatic stim_row_t reg_row(logic [2:0] i, logic [15:0] v);
		return '{ROW_REG, i, v, 16'd0, 1'b0, 1'b0, 1'b0, '0};
	endfunction

	localparam stim_row_t DIRECTED [31] = '{
		typed_row(16'h0000, 1'b0, 1'b0, AFTER_RESET),
		typed_row(16'hFFFF, 1'b1, 1'b1, AFTER_RESET),
		typed_row(16'h0000, 1'b1, 1'b0, FIRST_STEP),
		req_row(16'hFFFF, 1'b0, 1'b0),
		reg_row(REG_TARGET_V, 16'hFFFF),
		req_row(16'h0000, 1'b0, 1'b0),
		req_row(16'd100, 1'b0, 1'b0),
		req_row(16'hFFFF, 1'b0, 1'b0),
		req_row(16'h5555, 1'b0, 1'b1),
		req_row(16'hAAAA, 1'b0, 1'b0),
		req_row(16'hAAAA, 1'b1, 1'b0),
		reg_row(REG_PER_FLOOR, 16'd1),
		reg_row(REG_PER_CEIL, 16'hFFFF),
		reg_row(REG_PER_INC, 16'd4095),
		reg_row(REG_TARGET_V, 16'h0000),
		// big steps drive the period below zero, then the zero-ratio correction
		req_row(16'h0001, 1'b0, 1'b0),
		req_row(16'h8000, 1'b0, 1'b0),
		req_row(16'h7FFF, 1'b0, 1'b0),
		req_row(16'h0F0F, 1'b0, 1'b0),
		req_row(16'hF0F0, 1'b0, 1'b0),
		req_row(16'h3333, 1'b0, 1'b0),
		req_row(16'hCCCC, 1'b0, 1'b0),
		req_row(16'h0000, 1'b0, 1'b0),
		req_row(16'hFFFF, 1'b0, 1'b0),
		req_row(16'h00FF, 1'b0, 1'b0),
		req_row(16'hFF00, 1'b0, 1'b0),
		req_row(16'h1234, 1'b0, 1'b0),
		// inverted duty bounds: ceiling test wins
		reg_row(REG_DUTY_FLOOR, 16'hFFFF),
		reg_row(REG_DUTY_CEIL, 16'd1),
		req_row(16'h1234, 1'b1, 1'b0),
		req_row(16'h0000, 1'b0, 1'b0)
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] measured_input_voltage;
	logic        start_request;
	logic        stop_request;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] duty_count;
	logic [15:0] period_count;
	logic        is_running;
	logic        hit_ceiling;
	logic        hit_floor;

	// typed expectation travels with its request
	logic        req_typed;
	pwm_result_t req_want;

	pwm_result_t pwm_due[$];
	int          mismatches = 0;
	int          hold_asked = 0;
	bit          think_running = 1'b0;

	// register mirror
	bit [15:0] tgt_v = 16'd0;
	bit [15:0] duty_lo = 16'd1000;
	bit [15:0] duty_hi = 16'd36000;
	bit [15:0] per_lo = 16'd36000;
	bit [15:0] per_hi = 16'd40000;
	bit [11:0] per_step = 12'd100;

	// regulator state
	bit [15:0] duty_now = 16'd1000;
	bit [15:0] period_now = 16'd40000;
	bit        sweep_up = 1'b0;
	bit        active = 1'b0;
	bit        at_ceiling = 1'b0;
	bit        at_floor = 1'b0;

	spread_spectrum_duty_regulator_unit u_top (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_wr_en              (cfg_wr_en),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.measured_input_voltage (measured_input_voltage),
		.start_request          (start_request),
		.stop_request           (stop_request),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.duty_count             (duty_count),
		.period_count           (period_count),
		.is_running             (is_running),
		.hit_ceiling            (hit_ceiling),
		.hit_floor              (hit_floor)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void mirror_write(logic [2:0] idx, logic [15:0] val);
		case (idx)
			REG_TARGET_V:   tgt_v = val;
			REG_DUTY_FLOOR: duty_lo = val;
			REG_DUTY_CEIL:  duty_hi = val;
			REG_PER_FLOOR:  per_lo = val;
			REG_PER_CEIL:   per_hi = val;
			REG_PER_INC:    per_step = val[11:0];
			default: ;
		endcase
	endfunction

	function automatic pwm_result_t advance_regulator(bit [15:0] meas, bit start, bit stop);
		bit [31:0] ratio;
		longint    corr;
		longint    np;
		longint    nd;
		if (stop) begin
			active = 1'b0;
		end else if (start) begin
			active = 1'b1;
			duty_now = duty_lo;
		end
		if (active) begin
			corr = 0;
			if (duty_now != 16'd0) begin
				ratio = ({16'd0, period_now} * 32'd1000) / {16'd0, duty_now};
				if (ratio != 32'd0)
					corr = ({20'd0, per_step} * 32'd1000) / ratio;
			end
			// direction flips at or past a bound; the period itself is not held there
			if (!sweep_up) begin
				np = longint'(period_now) - longint'(per_step);
				corr = -corr;
				if (np <= longint'(per_lo))
					sweep_up = 1'b1;
			end else begin
				np = longint'(period_now) + longint'(per_step);
				if (np >= longint'(per_hi))
					sweep_up = 1'b0;
			end
			if (np < 0)
				np = 0;
			else if (np > 65535)
				np = 65535;
			period_now = np[15:0];
			nd = longint'(duty_now) + corr;
			nd = (tgt_v > meas) ? nd - longint'(DUTY_STEP) : nd + longint'(DUTY_STEP);
			at_ceiling = 1'b0;
			at_floor = 1'b0;
			if (nd >= longint'(duty_hi)) begin
				nd = duty_hi;
				at_ceiling = 1'b1;
			end else if (nd <= longint'(duty_lo)) begin
				nd = duty_lo;
				at_floor = 1'b1;
			end
			duty_now = nd[15:0];
		end
		return '{duty_now, period_now, active, at_ceiling, at_floor};
	endfunction

	// requests and register writes, sampled as the unit sees them
	always @(posedge clk) begin
		pwm_result_t got;
		if (arst_n) begin
			if (cfg_wr_en)
				mirror_write(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				got = advance_regulator(measured_input_voltage, start_request, stop_request);
				pwm_due.push_back(req_typed ? req_want : got);
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		pwm_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pwm_due.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = pwm_due.pop_front();
				check_field("duty_count", want.duty, duty_count);
				check_field("period_count", want.period, period_count);
				check_field("is_running", 16'(want.running), 16'(is_running));
				check_field("hit_ceiling", 16'(want.clamp_hi), 16'(hit_ceiling));
				check_field("hit_floor", 16'(want.clamp_lo), 16'(hit_floor));
			end
		end
	end

	// receiver: segments of random stall density, plus a long hold-off on request
	initial begin
		int hold_left;
		int seg_left;
		int pct;
		int served;
		hold_left = 0;
		seg_left = 0;
		pct = 0;
		served = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != served) begin
				served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(200, 20);
					case ($urandom_range(4))
						0, 1: pct = 0;
						2: pct = 25;
						3: pct = 50;
						default: pct = 90;
					endcase
				end
				seg_left--;
				out_stall <= ($urandom_range(99) < pct);
			end
		end
	end

	task automatic offer(stim_row_t row);
		in_valid <= 1'b1;
		measured_input_voltage <= row.meas;
		start_request <= row.start;
		stop_request <= row.stop;
		req_typed <= row.typed;
		req_want <= row.want;
		do @(posedge clk); while (in_stall);
		if (row.stop)
			think_running = 1'b0;
		else if (row.start)
			think_running = 1'b1;
	endtask

	task automatic idle_gap();
		int gap;
		case ($urandom_range(9))
			0, 1, 2: gap = 0;
			3, 4: gap = $urandom_range(80, 16);
			default: gap = $urandom_range(15, 1);
		endcase
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// always advances at least one edge
	task automatic await_quiet(int extra);
		do @(posedge clk); while (pwm_due.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_phase(int ph);
		logic [15:0] v [6];
		case (ph)
			0: v = '{16'd0, 16'd1000, 16'd36000, 16'd36000, 16'd40000, 16'd100};
			1: v = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd4095};
			2: v = '{16'h0000, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd1};
			default: begin
				v[0] = 16'($urandom);
				v[1] = 16'($urandom_range(40000, 1));
				v[2] = ($urandom_range(4) == 0) ? 16'($urandom_range(65535, 1))
					: 16'($urandom_range(65535, v[1]));
				v[3] = 16'($urandom_range(60000, 1));
				v[4] = ($urandom_range(4) == 0) ? 16'($urandom_range(65535, 1))
					: 16'($urandom_range(65535, v[3]));
				v[5] = ($urandom_range(2) == 0) ? 16'($urandom_range(4095, 1))
					: 16'($urandom_range(400, 1));
			end
		endcase
		write_reg(REG_TARGET_V, v[0]);
		write_reg(REG_DUTY_FLOOR, v[1]);
		write_reg(REG_DUTY_CEIL, v[2]);
		write_reg(REG_PER_FLOOR, v[3]);
		write_reg(REG_PER_CEIL, v[4]);
		write_reg(REG_PER_INC, v[5]);
	endtask

	// mostly regulation with the odd start or stop; restarts soon after a stop
	function automatic stim_row_t make_request();
		stim_row_t row;
		int pick;
		row = req_row(16'd0, 1'b0, 1'b0);
		pick = $urandom_range(99);
		if (think_running) begin
			row.stop = (pick < 4) || (pick >= 8 && pick < 10);
			row.start = pick >= 4 && pick < 10;
		end else begin
			row.start = pick < 75;
			row.stop = pick >= 65 && pick < 75;
		end
		case ($urandom_range(9))
			0: row.meas = 16'h0000;
			1: row.meas = 16'hFFFF;
			2: row.meas = tgt_v;
			3, 4, 5: row.meas = tgt_v + 16'($urandom_range(40)) - 16'd20;
			default: row.meas = 16'($urandom);
		endcase
		return row;
	endfunction

	initial begin
		int sent;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TARGET_V;
		cfg_data = 16'd0;
		in_valid = 1'b0;
		measured_input_voltage = 16'd0;
		start_request = 1'b0;
		stop_request = 1'b0;
		req_typed = 1'b0;
		req_want = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				in_valid <= 1'b0;
				await_quiet(4);
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				offer(DIRECTED[i]);
				idle_gap();
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			in_valid <= 1'b0;
			await_quiet(4);
			program_phase(ph);
			// long receiver hold-off while requests keep coming: the unit must back up
			if (ph == PRESSURE_PHASE)
				hold_asked <= hold_asked + 1;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				repeat ($urandom_range(30, 1)) begin
					if (sent < ITEMS_PER_PHASE) begin
						offer(make_request());
						sent++;
					end
				end
				if (ph != PRESSURE_PHASE && ph != NUM_PHASES - 1) begin
					if ($urandom_range(11) == 0) begin
						in_valid <= 1'b0;
						await_quiet(0);
					end else begin
						idle_gap();
					end
				end
			end
		end

		in_valid <= 1'b0;
		await_quiet(60);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#8ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: spread_spectrum_duty_regulator_unit.f
hdl/ssdr_pkg.sv
hdl/ssdr_div.sv
hdl/spread_spectrum_duty_regulator_unit.sv
bench/tb_spread_spectrum_duty_regulator_unit.sv
